// ===== design/grid_zone_adjacent_pairs_macros.svh =====
`ifndef GRID_ZONE_ADJACENT_PAIRS_MACROS_SVH
`define GRID_ZONE_ADJACENT_PAIRS_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define GZAP_ASSERT(lbl, ck, rs, pr) \
  lbl: assert property (@(posedge ck) disable iff (rs) pr) \
    else $error("grid zone pairs: assertion failed");

// Clocked assertion that is also checked while reset is high.
`define GZAP_ASSERT_ALWAYS(lbl, ck, pr) \
  lbl: assert property (@(posedge ck) pr) \
    else $error("grid zone pairs: assertion failed");

`endif

// ===== design/gzap_pkg.sv =====
package gzap_pkg;

  localparam int ZONE_W     = 10;
  localparam int ZONE_DEPTH = 1024;
  localparam int COLS_DEF   = 32;
  localparam int ROWS_DEF   = 32;
  localparam int DIV_SHIFT  = 20;
  localparam int NB_COUNT   = 8;
  localparam int NB_IDX_W   = 3;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Neighbour offsets as (row, column), visited in this order.
  localparam logic signed [1:0] NB_DROW [NB_COUNT] = '{
    2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1
  };
  localparam logic signed [1:0] NB_DCOL [NB_COUNT] = '{
    2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1
  };

endpackage

// ===== design/gzap_ram.sv =====
module gzap_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = gzap_pkg::ZONE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/grid_zone_adjacent_pairs.sv =====
// Channel  Direction  Beat contents (lowest bit first)
// s_*      in         tdata: zone_id[9:0], zeros; tuser: mode
// m_*      out        tdata: earlier_zone[9:0], new_zone[19:10], zeros; tlast: last
//
// A rejected add (zone outside the grid or already marked) passes ST_DIV and ST_CHECK
// and returns to ST_IDLE. An accepted add then runs ST_SCAN, ST_DRAIN and ST_EMIT:
// one mark is read per cycle through the single read port of the mark memory, and one
// pair leaves per cycle while m_tready is high. A clear item, and reset itself, start a
// sweep over all 1024 entries of the mark memory, during which s_tready is low.
// The output register lets a new item be taken while the last pair waits on m_tready.
module grid_zone_adjacent_pairs #(
  parameter int COLS = gzap_pkg::COLS_DEF,
  parameter int ROWS = gzap_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gzap_pkg::S_TDATA_W-1:0]  s_tdata,   // zone_id, zeros
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gzap_pkg::M_TDATA_W-1:0]  m_tdata,   // earlier_zone, new_zone, zeros
  output logic                            m_tlast
);

  localparam int ZW     = gzap_pkg::ZONE_W;
  localparam int GridW  = $clog2(ROWS * COLS + 1);
  localparam int AW     = (GridW > ZW) ? GridW : ZW;
  localparam int NW     = AW + 1;
  localparam int CW     = $clog2(COLS);
  localparam int SH     = gzap_pkg::DIV_SHIFT;
  localparam int PW     = ZW + SH;
  localparam int MW     = ZW + $clog2(COLS + 1);
  localparam int NBC    = gzap_pkg::NB_COUNT;
  localparam int KW     = gzap_pkg::NB_IDX_W;
  localparam int PADW   = gzap_pkg::M_TDATA_W - 2 * ZW;

  localparam logic [NW-1:0] TOTAL  = NW'(ROWS * COLS);
  localparam logic [NW-1:0] COLS_N = NW'(COLS);
  localparam logic [NW-1:0] DEPTH_N = NW'(gzap_pkg::ZONE_DEPTH);
  localparam logic [SH-1:0] RECIP  = SH'((1 << SH) / COLS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_CHECK, ST_SCAN, ST_DRAIN, ST_EMIT
  } state_t;

  state_t          state;
  logic [ZW-1:0]   clr_addr;
  logic [ZW-1:0]   zone;
  logic [PW-1:0]   prod;
  logic [ZW-1:0]   row;
  logic [CW-1:0]   col;
  logic [KW-1:0]   k;
  logic            pend_ok;
  logic [KW-1:0]   pend_k;
  logic [NBC-1:0]  hit;
  logic [ZW-1:0]   nb_id [NBC];

  logic            wr_en;
  logic [ZW-1:0]   wr_addr;
  logic            wr_data;
  logic            rd_en;
  logic [ZW-1:0]   rd_addr;
  logic            rd_data;

  logic [ZW-1:0]   q;
  logic [MW-1:0]   q_cols;
  logic [ZW-1:0]   rem;
  logic            rem_hi;
  logic [ZW-1:0]   row_c;
  logic [CW-1:0]   col_c;
  logic            in_grid;

  logic signed [1:0] dr;
  logic signed [1:0] dc;
  logic            row_ok;
  logic            col_ok;
  logic [NW-1:0]   nb_w;
  logic            nb_ok;

  logic [KW-1:0]   sel;
  logic [NBC-1:0]  rest;

  gzap_ram #(
    .WIDTH (1),
    .DEPTH (gzap_pkg::ZONE_DEPTH)
  ) u_marks (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == ST_IDLE);

  // Row and column from the zone: reciprocal estimate, then one correction step.
  always_comb begin
    q       = prod[PW-1:SH];
    q_cols  = MW'(q) * MW'(COLS);
    rem     = ZW'(MW'(zone) - q_cols);
    rem_hi  = (rem >= ZW'(COLS));
    row_c   = rem_hi ? ZW'(q + 1'b1) : q;
    col_c   = rem_hi ? CW'(rem - ZW'(COLS)) : CW'(rem);
    in_grid = (NW'(zone) < TOTAL);
  end

  always_comb begin
    dr     = gzap_pkg::NB_DROW[k];
    dc     = gzap_pkg::NB_DCOL[k];
    row_ok = !((dr == -2'sd1 && row == '0) || (dr == 2'sd1 && row == ZW'(ROWS - 1)));
    col_ok = !((dc == -2'sd1 && col == '0) || (dc == 2'sd1 && col == CW'(COLS - 1)));
    nb_w   = NW'(zone);
    if (dr == 2'sd1) begin
      nb_w = nb_w + COLS_N;
    end else if (dr == -2'sd1) begin
      nb_w = nb_w - COLS_N;
    end
    if (dc == 2'sd1) begin
      nb_w = nb_w + NW'(1);
    end else if (dc == -2'sd1) begin
      nb_w = nb_w - NW'(1);
    end
    nb_ok = row_ok && col_ok && (nb_w < DEPTH_N);
  end

  always_comb begin
    sel = '0;
    for (int i = NBC - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = KW'(i);
      end
    end
    rest = hit & ~(NBC'(1) << sel);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 1'b0;
    rd_en   = 1'b0;
    rd_addr = zone;
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_DIV: begin
        rd_en = 1'b1;
      end
      ST_CHECK: begin
        wr_en   = in_grid && !rd_data;
        wr_addr = zone;
        wr_data = 1'b1;
      end
      ST_SCAN: begin
        rd_en   = nb_ok;
        rd_addr = nb_w[ZW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(state == ST_EMIT && hit != '0)) begin
        m_tvalid <= 1'b0;
      end
      if ((state == ST_SCAN || state == ST_DRAIN) && pend_ok && rd_data) begin
        hit[pend_k] <= 1'b1;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ZW'(gzap_pkg::ZONE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            zone <= s_tdata[ZW-1:0];
            if (s_tuser == gzap_pkg::MODE_CLEAR) begin
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          prod  <= PW'(zone) * PW'(RECIP);
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          row     <= row_c;
          col     <= col_c;
          k       <= '0;
          pend_ok <= 1'b0;
          hit     <= '0;
          if (in_grid && !rd_data) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          pend_ok     <= nb_ok;
          pend_k      <= k;
          nb_id[k]    <= nb_w[ZW-1:0];
          k           <= k + 1'b1;
          if (k == KW'(NBC - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend_ok <= 1'b0;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (hit == '0) begin
            state <= ST_IDLE;
          end else if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {PADW'(0), zone, nb_id[sel]};
            m_tlast  <= (rest == '0);
            hit      <= rest;
            if (rest == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/gzap_checker.sv =====
`include "grid_zone_adjacent_pairs_macros.svh"

module gzap_checker #(
  parameter int COLS = gzap_pkg::COLS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gzap_pkg::M_TDATA_W-1:0] m_tdata,   // earlier_zone, new_zone, zeros
  input logic                           m_tlast
);

  localparam int ZW = gzap_pkg::ZONE_W;
  localparam int DW = ZW + 2;

  localparam logic signed [DW-1:0] C_ONE  = DW'(1);
  localparam logic signed [DW-1:0] C_COL  = DW'(COLS);
  localparam logic signed [DW-1:0] C_COLM = DW'(COLS - 1);
  localparam logic signed [DW-1:0] C_COLP = DW'(COLS + 1);

  logic signed [DW-1:0] diff;
  logic                 adjacent;

  // A pair always names two zones that touch, so their ids differ by one of these steps.
  always_comb begin
    diff = $signed({2'b00, m_tdata[2*ZW-1:ZW]}) - $signed({2'b00, m_tdata[ZW-1:0]});
    adjacent = diff == C_ONE || diff == -C_ONE || diff == C_COL || diff == -C_COL ||
               diff == C_COLM || diff == -C_COLM || diff == C_COLP || diff == -C_COLP;
  end

  `GZAP_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `GZAP_ASSERT(a_pair_adjacent, clk, rst, m_tvalid |-> adjacent)
  `GZAP_ASSERT(a_one_item_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `GZAP_ASSERT_ALWAYS(a_sweep_after_reset, clk, rst |=> !s_tready)

endmodule

bind grid_zone_adjacent_pairs gzap_checker #(.COLS(COLS)) u_gzap_checker (.*);

// ===== dv/grid_zone_adjacent_pairs_checker.sv =====
module grid_zone_adjacent_pairs_checker #(
  parameter int COLS = gzap_pkg::COLS_DEF,
  parameter int ROWS = gzap_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [gzap_pkg::S_TDATA_W-1:0]  s_tdata,   // zone_id, zeros
  input  logic                            s_tuser,   // mode
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [gzap_pkg::M_TDATA_W-1:0]  m_tdata,   // earlier_zone, new_zone, zeros
  input  logic                            m_tlast,
  output int                              errors,
  output int                              pending
);

  import gzap_pkg::*;

  typedef struct packed {
    logic [ZONE_W-1:0] earlier;
    logic [ZONE_W-1:0] added;
    logic              last;
  } zone_pair_t;

  localparam int ROW_STEP [8] = '{0, 0, 1, -1, 1, 1, -1, -1};
  localparam int COL_STEP [8] = '{1, -1, 0, 0, -1, 1, -1, 1};

  logic       zone_marks [ZONE_DEPTH];
  zone_pair_t pair_q [$];
  int         fail_cnt = 0;

  // Clear unmarks all; add marks zone, queues one pair per marked neighbour in order.
  task automatic predict_pairs(input logic mode, input logic [ZONE_W-1:0] zone);
    int         row;
    int         col;
    int         r;
    int         c;
    int         nb;
    int         hits;
    int         nb_ids [8];
    zone_pair_t pair;
    if (mode == MODE_CLEAR) begin
      foreach (zone_marks[i]) zone_marks[i] = 1'b0;
      return;
    end
    if (int'(zone) >= ROWS * COLS || zone_marks[zone]) return;
    zone_marks[zone] = 1'b1;
    row  = int'(zone) / COLS;
    col  = int'(zone) % COLS;
    hits = 0;
    for (int k = 0; k < 8; k++) begin
      r = row + ROW_STEP[k];
      c = col + COL_STEP[k];
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) continue;
      nb = r * COLS + c;
      if (nb >= ZONE_DEPTH) continue;
      if (!zone_marks[nb]) continue;
      nb_ids[hits] = nb;
      hits++;
    end
    for (int k = 0; k < hits; k++) begin
      pair.earlier = nb_ids[k][ZONE_W-1:0];
      pair.added   = zone;
      pair.last    = (k == hits - 1);
      pair_q.push_back(pair);
    end
  endtask

  always @(posedge clk) begin : watch
    zone_pair_t want;
    if (rst) begin
      foreach (zone_marks[i]) zone_marks[i] = 1'b0;
      pair_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pair_q.size() == 0) begin
          $error("unexpected pair beat: earlier_zone %0d, new_zone %0d, last %0b",
                 m_tdata[ZONE_W-1:0], m_tdata[2*ZONE_W-1:ZONE_W], m_tlast);
          fail_cnt++;
        end else begin
          want = pair_q.pop_front();
          if (m_tdata[ZONE_W-1:0] !== want.earlier) begin
            $error("earlier_zone: expected %0d, actual %0d", want.earlier,
                   m_tdata[ZONE_W-1:0]);
            fail_cnt++;
          end
          if (m_tdata[2*ZONE_W-1:ZONE_W] !== want.added) begin
            $error("new_zone: expected %0d, actual %0d", want.added,
                   m_tdata[2*ZONE_W-1:ZONE_W]);
            fail_cnt++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_tlast);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_pairs(s_tuser, s_tdata[ZONE_W-1:0]);
    end
    errors  <= fail_cnt;
    pending <= pair_q.size();
  end

endmodule

// ===== dv/grid_zone_adjacent_pairs_tb.sv =====
module grid_zone_adjacent_pairs_tb;

  import gzap_pkg::*;

  localparam int GRID_COLS = COLS_DEF;
  localparam int GRID_ROWS = ROWS_DEF;
  localparam int HOLD_LEN  = 300;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  int                    errors;
  int                    pending;

  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_req = 0;

  grid_zone_adjacent_pairs #(.COLS(GRID_COLS), .ROWS(GRID_ROWS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  grid_zone_adjacent_pairs_checker #(.COLS(GRID_COLS), .ROWS(GRID_ROWS)) u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic send_beat(input logic mode, input int zone);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99, 0) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= S_TDATA_W'(zone[ZONE_W-1:0]);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // The receiver; a hold request keeps it stalled long enough to back the block up.
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_seen = hold_req;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int   sent;
    int   phase;
    int   w;
    int   r0;
    int   c0;
    int   burst;
    int   roll;
    int   zone;
    int   ring [8];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_ADD;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Corners, a repeated zone, row edges that must not wrap, a clear, a full ring.
    send_beat(MODE_ADD, 0);
    send_beat(MODE_ADD, 0);
    send_beat(MODE_ADD, 1);
    send_beat(MODE_ADD, 32);
    send_beat(MODE_ADD, 31);
    send_beat(MODE_ADD, 63);
    send_beat(MODE_ADD, 64);
    send_beat(MODE_ADD, 1023);
    send_beat(MODE_ADD, 992);
    send_beat(MODE_ADD, 1022);
    send_beat(MODE_CLEAR, 1023);
    send_beat(MODE_ADD, 1);
    ring = '{164, 166, 133, 134, 132, 196, 197, 198};
    foreach (ring[i]) send_beat(MODE_ADD, ring[i]);
    send_beat(MODE_ADD, 165);
    send_beat(MODE_CLEAR, 0);
    send_beat(MODE_ADD, 0);

    // Clustered adds so that neighbours are usually populated; some noise and clears.
    sent = 0;
    while (sent < 248) begin
      phase = (sent / 34) % 4;
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 67;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 67;
        end
        default: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 33;
        end
      endcase
      if (sent == 0) hold_req++;
      w = $urandom_range(5, 3);
      if ($urandom_range(2, 0) == 0) begin
        r0 = $urandom_range(1, 0) ? 0 : GRID_ROWS - w;
        c0 = $urandom_range(1, 0) ? 0 : GRID_COLS - w;
      end else begin
        r0 = $urandom_range(GRID_ROWS - w, 0);
        c0 = $urandom_range(GRID_COLS - w, 0);
      end
      burst = $urandom_range(16, 6);
      repeat (burst) begin
        roll = $urandom_range(99, 0);
        if (roll < 4) begin
          send_beat(MODE_CLEAR, $urandom_range(ZONE_DEPTH - 1, 0));
        end else if (roll < 12) begin
          send_beat(MODE_ADD, $urandom_range(ZONE_DEPTH - 1, 0));
        end else begin
          zone = (r0 + $urandom_range(w - 1, 0)) * GRID_COLS + c0
                 + $urandom_range(w - 1, 0);
          send_beat(MODE_ADD, zone);
        end
        sent++;
      end
    end

    s_tvalid     <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("grid_zone_adjacent_pairs_tb: done, clean");
    end else begin
      $display("grid_zone_adjacent_pairs_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(20 * 400000);
    $display("grid_zone_adjacent_pairs_tb: done, errors");
    $finish;
  end

endmodule
